@@ sv/hict_pkg.sv @@
// Shared widths, status codes and sizing constants for the chained hash table.
package hict_pkg;

  // Field widths fixed by the interface
  localparam int HASH_W   = 32;
  localparam int VAL_W    = 8;
  localparam int CNT_W    = 9;
  localparam int STATUS_W = 2;

  // Table sizing
  localparam int ENTRY_SLOTS  = 256;
  localparam int BUCKET_SLOTS = 256;
  localparam int ENTRY_W      = $clog2(ENTRY_SLOTS);
  localparam int USED_W       = ENTRY_W + 1;
  localparam int BKT_W        = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;

  // Remainder unit: quotient bits retired per cycle
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = HASH_W / MOD_BITS;
  localparam int MOD_CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  // Bucket count register reset
  localparam logic [CNT_W-1:0] BUCKET_COUNT_RESET = CNT_W'(256);

  // Operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // Status of the remainder unit as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

@@ sv/hict_mod.sv @@
// Iterative remainder unit: 32-bit hash modulo a 9-bit bucket count.
module hict_mod (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [hict_pkg::HASH_W-1:0]  dividend,
  input  logic [hict_pkg::CNT_W-1:0]   divisor,
  output hict_pkg::mod_stat_t          stat,
  output logic [hict_pkg::CNT_W-1:0]   remainder
);

  logic [hict_pkg::HASH_W-1:0]    quo;
  logic [hict_pkg::CNT_W-1:0]     div;
  logic [hict_pkg::CNT_W-1:0]     rem;
  logic [hict_pkg::MOD_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic [hict_pkg::HASH_W-1:0]    quo_next;
  logic [hict_pkg::CNT_W-1:0]     rem_next;

  // Retire several dividend bits: shift in, compare, subtract
  always_comb begin
    logic [hict_pkg::CNT_W:0] trial;
    trial    = '0;
    quo_next = quo;
    rem_next = rem;
    for (int k = 0; k < hict_pkg::MOD_BITS; k++) begin
      trial = {rem_next, quo_next[hict_pkg::HASH_W-1]};
      if (trial >= {1'b0, div}) begin
        trial = trial - {1'b0, div};
      end
      rem_next = trial[hict_pkg::CNT_W-1:0];
      quo_next = {quo_next[hict_pkg::HASH_W-2:0], 1'b0};
    end
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + hict_pkg::MOD_CNT_W'(1);
        if (cnt == hict_pkg::MOD_CNT_W'(hict_pkg::MOD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      div <= divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem;

endmodule

@@ sv/hash_index_chained_table.sv @@
// Top level of the chained hash table: sequencer, bucket heads and entry memories.
//
// Each item is an insert (func 0) or a lookup (func 1) of a 32-bit hash. The bucket
// is the hash modulo the bucket count register (0 acts as 1, values above the
// bucket capacity saturate), found by a shared remainder unit that retires four
// bits a cycle in 8 steps. An insert then reads the bucket head and links the next
// free slot in front of it. A lookup reads the head and walks the chain through
// the entry memory, one entry per cycle. Newer inserts sit nearer the head and win
// on duplicate hashes. The block takes one item at a time; a finished result waits
// in the output register while the next item is taken. Bucket heads are empty
// after reset with no clearing pass. Write bucket_count only while idle.
module hash_index_chained_table (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hict_pkg::CNT_W-1:0]     bucket_count,
  // input items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic [hict_pkg::HASH_W-1:0]    hash,
  input  logic [hict_pkg::VAL_W-1:0]     stored_index,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hict_pkg::STATUS_W-1:0]  status,
  output logic [hict_pkg::VAL_W-1:0]     found_value
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam int BUCKET_SLOTS_M1 = hict_pkg::BUCKET_SLOTS - 1;

  logic [2:0]                      state;
  logic [2:0]                      state_next;
  logic [hict_pkg::CNT_W-1:0]      bucket_cfg;
  logic [hict_pkg::CNT_W-1:0]      eff_count;
  logic                            in_accept;
  logic                            out_take;
  logic                            out_load;

  // item registers
  logic                            op_func;
  logic [hict_pkg::HASH_W-1:0]     key_hash;
  logic [hict_pkg::VAL_W-1:0]      key_value;
  logic [hict_pkg::BKT_W-1:0]      bucket;
  logic [hict_pkg::BKT_W-1:0]      bucket_next;
  logic [hict_pkg::STATUS_W-1:0]   res_status;
  logic [hict_pkg::VAL_W-1:0]      res_value;
  logic [hict_pkg::USED_W-1:0]     slots_used;
  logic                            table_full;

  // remainder unit
  hict_pkg::mod_stat_t             mstat;
  logic [hict_pkg::CNT_W-1:0]      mod_rem;

  // bucket heads: valid flops plus index memory
  logic [BUCKET_SLOTS_M1:0]        head_valid;
  logic [hict_pkg::ENTRY_W-1:0]    head_mem [hict_pkg::BUCKET_SLOTS];
  logic [hict_pkg::ENTRY_W-1:0]    head_rd;
  logic                            head_vld_rd;
  logic                            head_rd_en;
  logic                            ins_we;

  // entry memories; next holds {valid, slot}
  logic [hict_pkg::HASH_W-1:0]     ent_hash_mem  [hict_pkg::ENTRY_SLOTS];
  logic [hict_pkg::VAL_W-1:0]      ent_value_mem [hict_pkg::ENTRY_SLOTS];
  logic [hict_pkg::ENTRY_W:0]      ent_next_mem  [hict_pkg::ENTRY_SLOTS];
  logic [hict_pkg::HASH_W-1:0]     ent_hash_rd;
  logic [hict_pkg::VAL_W-1:0]      ent_value_rd;
  logic [hict_pkg::ENTRY_W:0]      ent_next_rd;
  logic                            ent_rd_en;
  logic [hict_pkg::ENTRY_W-1:0]    ent_rd_addr;
  logic [hict_pkg::ENTRY_W-1:0]    ins_slot;
  logic                            hit;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_cfg <= hict_pkg::BUCKET_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bucket_cfg <= bucket_count;
    end
  end

  // Clamp the bucket count to the usable range
  always_comb begin
    if (bucket_cfg == '0) begin
      eff_count = hict_pkg::CNT_W'(1);
    end else if (32'(bucket_cfg) > 32'(hict_pkg::BUCKET_SLOTS)) begin
      eff_count = hict_pkg::CNT_W'(hict_pkg::BUCKET_SLOTS);
    end else begin
      eff_count = bucket_cfg;
    end
  end

  // Handshakes
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  hict_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (in_accept),
    .dividend  (hash),
    .divisor   (eff_count),
    .stat      (mstat),
    .remainder (mod_rem)
  );

  assign bucket_next = hict_pkg::BKT_W'(mod_rem);
  assign table_full  = (slots_used == hict_pkg::USED_W'(hict_pkg::ENTRY_SLOTS));
  assign ins_slot    = slots_used[hict_pkg::ENTRY_W-1:0];
  assign hit         = (ent_hash_rd == key_hash);
  assign head_rd_en  = (state == S_MOD) && mstat.done;
  assign ins_we      = (state == S_HEAD) && (op_func == hict_pkg::FUNC_INSERT) && !table_full;

  // Pick the next entry to fetch: chain head, then each next link
  always_comb begin
    ent_rd_en   = 1'b0;
    ent_rd_addr = head_rd;
    if (state == S_HEAD && op_func == hict_pkg::FUNC_LOOKUP && head_vld_rd) begin
      ent_rd_en = 1'b1;
    end else if (state == S_CMP && !hit && ent_next_rd[hict_pkg::ENTRY_W]) begin
      ent_rd_en   = 1'b1;
      ent_rd_addr = ent_next_rd[hict_pkg::ENTRY_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_accept) state_next = S_MOD;
      S_MOD:  if (mstat.done) state_next = S_HEAD;
      S_HEAD: begin
        if (op_func == hict_pkg::FUNC_LOOKUP && head_vld_rd) begin
          state_next = S_CMP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CMP:  if (!ent_rd_en) state_next = S_DONE;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the item and form the result
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_func   <= func;
      key_hash  <= hash;
      key_value <= stored_index;
    end
    if (head_rd_en) begin
      bucket <= bucket_next;
    end
    case (state)
      S_HEAD: begin
        res_value <= '0;
        if (op_func == hict_pkg::FUNC_INSERT) begin
          res_status <= table_full ? hict_pkg::ST_FULL : hict_pkg::ST_OK;
        end else begin
          res_status <= hict_pkg::ST_MISS;
        end
      end
      S_CMP: begin
        if (hit) begin
          res_status <= hict_pkg::ST_OK;
          res_value  <= ent_value_rd;
        end
      end
      default: ;
    endcase
  end

  // Count taken slots; set a bucket's valid bit on its first insert
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
      head_valid <= '0;
    end else if (ins_we) begin
      slots_used         <= slots_used + hict_pkg::USED_W'(1);
      head_valid[bucket] <= 1'b1;
    end
  end

  // Bucket head memory
  always_ff @(posedge clk) begin
    if (ins_we) begin
      head_mem[bucket] <= ins_slot;
    end
    if (head_rd_en) begin
      head_rd     <= head_mem[bucket_next];
      head_vld_rd <= head_valid[bucket_next];
    end
  end

  // Entry memories
  always_ff @(posedge clk) begin
    if (ins_we) begin
      ent_hash_mem[ins_slot]  <= key_hash;
      ent_value_mem[ins_slot] <= key_value;
      ent_next_mem[ins_slot]  <= {head_vld_rd, head_rd};
    end
    if (ent_rd_en) begin
      ent_hash_rd  <= ent_hash_mem[ent_rd_addr];
      ent_value_rd <= ent_value_mem[ent_rd_addr];
      ent_next_rd  <= ent_next_mem[ent_rd_addr];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res_status;
      found_value <= res_value;
    end
  end

  // Checks
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    32'(slots_used) <= 32'(hict_pkg::ENTRY_SLOTS))
    else $error("slot count past capacity");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    ins_we |=> slots_used == $past(slots_used) + hict_pkg::USED_W'(1))
    else $error("insert did not take a slot");

  a_mod_done_state: assert property (@(posedge clk) disable iff (rst)
    mstat.done |-> state == S_MOD)
    else $error("remainder finished outside its wait state");

  a_idle_unit_free: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mstat.busy)
    else $error("remainder unit busy while idle");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != hict_pkg::ST_OK |-> found_value == '0)
    else $error("value reported without a hit");

endmodule
